/* design/mtrr_pkg.sv */
// Shared types and constants for the MTRR memory type resolver.
package mtrr_pkg;

    // Table sizes and address width.
    localparam int VAR_ENTRIES = 8;
    localparam int PHYS_BITS   = 52;
    localparam int FIXED_WORDS = 11;
    localparam int ADDR_W      = 52;
    localparam int WORD_W      = 64;
    localparam int SLOT_W      = 4;
    localparam int TYPE_W      = 8;
    localparam int FIX_IDX_W   = $clog2(FIXED_WORDS);

    // Address bits that take part in a variable-range compare.
    localparam logic [63:0] PHYS_ONES = (64'd1 << PHYS_BITS) - 64'd1;
    localparam logic [ADDR_W-1:0] PFN_MASK = PHYS_ONES[ADDR_W-1:0] & ~ADDR_W'(12'hFFF);

    // Bit of a variable mask word that marks the entry valid.
    localparam int MASK_VALID_BIT = 11;

    // Codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FIXED  = 2'd1,
        KIND_BASE   = 2'd2,
        KIND_MASK   = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FIXED_ENABLE   = 2'd0,
        REG_VARIABLE_COUNT = 2'd1,
        REG_DEFAULT_TYPE   = 2'd2
    } cfg_reg_t;

    // One word travelling down the row of cells.
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] address;
        logic              hit;
        logic [TYPE_W-1:0] mem_type;
    } token_t;

endpackage

/* design/mtrr_memory_type_resolver.sv */
// Top level of the MTRR memory type resolver: configuration port and row of cells.
//
// Use: every word on the item channel (item_valid, item_stall) is a lookup or a
// table write, chosen by kind. A write loads a fixed-range word or a variable
// base or mask and gives no result. A lookup gives one word on the result
// channel (result_valid, result_stall) carrying mem_type.
// Items pass down a row of VAR_ENTRIES cells (8 with the present table), each
// registering the word, and a lookup comes out of the register of the last cell.
// A new word is taken in every cycle that the row is not stalled; the throughput
// of one word per cycle is set by the row advancing as a whole. Writes to
// variable entries travel down the row with the lookups, so every lookup sees
// exactly the writes that were accepted before it.
// When the receiver stalls a waiting result, the whole row holds and item_stall
// is raised in the same cycle; nothing is lost or repeated.
// Reset clears all tables and configuration registers and empties the row.
// fixed_enable, variable_count and default_type are written over APB at byte
// addresses 0, 4 and 8, by the user only with no lookup in the row; unenforced.
module mtrr_memory_type_resolver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  kind,
    input  logic [mtrr_pkg::SLOT_W-1:0] slot,
    input  logic [mtrr_pkg::WORD_W-1:0] word,
    input  logic [mtrr_pkg::ADDR_W-1:0] address,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [mtrr_pkg::TYPE_W-1:0] mem_type,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mtrr_pkg::*;

    logic              fixed_enable_reg;
    logic [3:0]        variable_count_reg;
    logic [TYPE_W-1:0] default_type_reg;
    logic              cfg_write;
    cfg_reg_t          cfg_sel;
    logic              advance;
    logic              accept;
    token_t            entry_token;
    token_t            chain [VAR_ENTRIES];
    token_t            last_token;

    // Configuration port: no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_enable_reg   <= 1'b0;
            variable_count_reg <= '0;
            default_type_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_FIXED_ENABLE:   fixed_enable_reg   <= pwdata[0];
                REG_VARIABLE_COUNT: variable_count_reg <= pwdata[3:0];
                REG_DEFAULT_TYPE:   default_type_reg   <= pwdata[TYPE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_sel)
            REG_FIXED_ENABLE:   prdata = {31'd0, fixed_enable_reg};
            REG_VARIABLE_COUNT: prdata = {28'd0, variable_count_reg};
            REG_DEFAULT_TYPE:   prdata = {24'd0, default_type_reg};
            default:            prdata = '0;
        endcase
    end

    // The row moves as one unless a finished result is held by the receiver.
    assign item_stall = result_valid && result_stall;
    assign advance    = !item_stall;
    assign accept     = item_valid && advance;

    mtrr_fixed u_fixed (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .fixed_enable (fixed_enable_reg),
        .default_type (default_type_reg),
        .kind         (kind),
        .slot         (slot),
        .word         (word),
        .address      (address),
        .valid        (item_valid),
        .token        (entry_token)
    );

    // Row of variable-range cells.
    for (genvar i = 0; i < VAR_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            mtrr_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .advance        (advance),
                .cell_index     (SLOT_W'(i)),
                .variable_count (variable_count_reg),
                .token_in       (entry_token),
                .token_out      (chain[i])
            );
        end
        else
        begin : g_next
            mtrr_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .advance        (advance),
                .cell_index     (SLOT_W'(i)),
                .variable_count (variable_count_reg),
                .token_in       (chain[i-1]),
                .token_out      (chain[i])
            );
        end
    end

    // Result: lookups only; an unsettled lookup takes the default type.
    assign last_token   = chain[VAR_ENTRIES-1];
    assign result_valid = last_token.valid && (last_token.kind == KIND_LOOKUP);
    assign mem_type     = last_token.hit ? last_token.mem_type : default_type_reg;

    // An accepted word always enters the first cell.
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> chain[0].valid)
        else $error("accepted word did not enter the row");

    // A write word never shows up as a result.
    a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (last_token.valid && last_token.kind != KIND_LOOKUP) |-> !result_valid)
        else $error("write word produced a result");

    // With no variable entries searched, a lookup at or above 1 MiB is unmatched.
    a_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && variable_count_reg == '0
         && last_token.address[ADDR_W-1:20] != '0) |-> !last_token.hit)
        else $error("variable match with no entries searched");

    // A held result keeps its type while the configuration is quiet.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_stall && !cfg_write) |=> $stable(mem_type))
        else $error("held result changed");

endmodule

/* design/mtrr_fixed.sv */
// Front stage: fixed-range table, fixed lookups and building of the entry token.
module mtrr_fixed (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        fixed_enable,
    input  logic [mtrr_pkg::TYPE_W-1:0] default_type,
    input  logic [1:0]                  kind,
    input  logic [mtrr_pkg::SLOT_W-1:0] slot,
    input  logic [mtrr_pkg::WORD_W-1:0] word,
    input  logic [mtrr_pkg::ADDR_W-1:0] address,
    input  logic                        valid,
    output mtrr_pkg::token_t            token
);
    import mtrr_pkg::*;

    logic [WORD_W-1:0]    fixed_words_reg [FIXED_WORDS];
    logic [FIX_IDX_W-1:0] word_sel;
    logic [2:0]           byte_sel;
    logic [WORD_W-1:0]    sel_word;
    logic                 low_region;
    kind_t                kind_code;

    assign kind_code = kind_t'(kind);

    // Fixed-range words are loaded when a fixed write word is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIXED_WORDS; i++)
            begin
                fixed_words_reg[i] <= '0;
            end
        end
        else if (accept && kind_code == KIND_FIXED && slot < SLOT_W'(FIXED_WORDS))
        begin
            fixed_words_reg[slot[FIX_IDX_W-1:0]] <= word;
        end
    end

    // Granule decode: 64 KiB below 0x80000, 16 KiB below 0xC0000, 4 KiB above.
    always_comb
    begin
        if (!address[19])
        begin
            word_sel = FIX_IDX_W'(0);
            byte_sel = address[18:16];
        end
        else if (!address[18])
        begin
            word_sel = FIX_IDX_W'(1) + FIX_IDX_W'(address[17]);
            byte_sel = address[16:14];
        end
        else
        begin
            word_sel = FIX_IDX_W'(3) + FIX_IDX_W'(address[17:15]);
            byte_sel = address[14:12];
        end
    end

    assign sel_word   = fixed_words_reg[word_sel];
    assign low_region = (address[ADDR_W-1:20] == '0);

    // Below 1 MiB the lookup is settled here, so no variable entry can claim
    // it; with the fixed ranges off it takes the default type straight away.
    always_comb
    begin
        token.valid    = valid;
        token.kind     = kind_code;
        token.slot     = slot;
        token.word     = word;
        token.address  = address;
        token.hit      = low_region;
        token.mem_type = sel_word[{byte_sel, 3'b000} +: TYPE_W];
        if (low_region && !fixed_enable)
        begin
            token.mem_type = default_type;
        end
    end

endmodule

/* design/mtrr_cell.sv */
// One variable-range cell: holds a base/mask pair and checks passing lookups.
module mtrr_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [mtrr_pkg::SLOT_W-1:0] cell_index,
    input  logic [3:0]                  variable_count,
    input  mtrr_pkg::token_t            token_in,
    output mtrr_pkg::token_t            token_out
);
    import mtrr_pkg::*;

    logic [WORD_W-1:0] base_reg;
    logic [WORD_W-1:0] mask_reg;
    logic              valid_reg;
    token_t            token_reg;
    token_t            token_next;
    logic              active;
    logic              entry_valid;
    logic              match;
    logic              is_lookup;

    assign active      = (cell_index < variable_count);
    assign entry_valid = mask_reg[MASK_VALID_BIT];
    assign match       = (((token_in.address ^ base_reg[ADDR_W-1:0])
                           & mask_reg[ADDR_W-1:0] & PFN_MASK) == '0);
    assign is_lookup   = (token_in.kind == KIND_LOOKUP);

    // A write word for this entry updates the pair as it passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            mask_reg <= '0;
        end
        else if (advance && token_in.valid && token_in.slot == cell_index)
        begin
            if (token_in.kind == KIND_BASE)
            begin
                base_reg <= token_in.word;
            end
            else if (token_in.kind == KIND_MASK)
            begin
                mask_reg <= token_in.word;
            end
        end
    end

    // First matching entry wins: a lookup already settled passes unchanged.
    always_comb
    begin
        token_next = token_in;
        if (is_lookup && !token_in.hit && active && entry_valid && match)
        begin
            token_next.hit      = 1'b1;
            token_next.mem_type = base_reg[TYPE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= token_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            token_reg <= token_next;
        end
    end

    always_comb
    begin
        token_out       = token_reg;
        token_out.valid = valid_reg;
    end

endmodule

/* tb/mtrr_memory_type_resolver_test.sv */
// Self-checking testbench for the MTRR memory type resolver: random traffic against a predictor.
module mtrr_memory_type_resolver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mtrr_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int ROW_SETTLE     = VAR_ENTRIES + 4;
    localparam int RANDOM_WORDS   = 210;
    localparam int HOLD_INTERVAL  = 600;
    localparam int HOLD_LENGTH    = 120;
    localparam int PLAN_STEPS     = 6;
    localparam logic [ADDR_W-1:0] ONE_MIB = ADDR_W'(32'h0010_0000);

    // One word on the item channel.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] address;
    } item_word_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    item_word_t        offered = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [TYPE_W-1:0] mem_type;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Words waiting to be offered and memory types still to come back.
    item_word_t        queued_words[$];
    logic [TYPE_W-1:0] predicted_types[$];

    // Predictor copy of the tables and the configuration.
    logic [WORD_W-1:0] fixed_range_words [FIXED_WORDS];
    logic [WORD_W-1:0] var_base_words [VAR_ENTRIES];
    logic [WORD_W-1:0] var_mask_words [VAR_ENTRIES];
    logic              cfg_fixed_enable = 1'b0;
    logic [3:0]        cfg_variable_count = '0;
    logic [TYPE_W-1:0] cfg_default_type = '0;

    // Page addresses that random bases and lookups share, so that entries hit.
    logic [ADDR_W-1:0] region_pages [4];

    int fault_count = 0;
    int accepted_items = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 300;
    int pattern_left = 0;
    stall_mode_t pattern_mode = STALL_NONE;

    mtrr_memory_type_resolver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (offered.kind),
        .slot         (offered.slot),
        .word         (offered.word),
        .address      (offered.address),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mem_type     (mem_type),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Memory type that the tables give for one address.
    function automatic logic [TYPE_W-1:0] predict_mem_type(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] granule;
        logic [ADDR_W-1:0] match_bits;
        int first_word;
        int word_idx;
        int searched;
        if (addr < ONE_MIB)
        begin
            if (!cfg_fixed_enable)
                return cfg_default_type;
            if (addr < ADDR_W'(32'h0008_0000))
            begin
                first_word = 0;
                granule = addr >> 16;
            end
            else if (addr < ADDR_W'(32'h000C_0000))
            begin
                first_word = 1;
                granule = (addr - ADDR_W'(32'h0008_0000)) >> 14;
            end
            else
            begin
                first_word = 3;
                granule = (addr - ADDR_W'(32'h000C_0000)) >> 12;
            end
            word_idx = first_word + int'(granule >> 3);
            if (word_idx >= FIXED_WORDS)
                return '0;
            return TYPE_W'(fixed_range_words[word_idx] >> {granule[2:0], 3'b000});
        end
        searched = (cfg_variable_count > VAR_ENTRIES) ? VAR_ENTRIES : int'(cfg_variable_count);
        for (int i = 0; i < searched; i++)
        begin
            match_bits = var_mask_words[i][ADDR_W-1:0] & PFN_MASK;
            if (var_mask_words[i][MASK_VALID_BIT] &&
                ((addr & match_bits) == (var_base_words[i][ADDR_W-1:0] & match_bits)))
                return var_base_words[i][TYPE_W-1:0];
        end
        return cfg_default_type;
    endfunction

    function automatic void queue_item(kind_t k, logic [SLOT_W-1:0] s, logic [WORD_W-1:0] w,
                                       logic [ADDR_W-1:0] a);
        item_word_t it;
        it.kind = k;
        it.slot = s;
        it.word = w;
        it.address = a;
        queued_words.push_back(it);
    endfunction

    // Random word: mostly well-formed table writes and lookups aimed at the shared pages.
    function automatic item_word_t make_random_item();
        item_word_t it;
        int pick;
        int shift;
        int page;
        pick = $urandom_range(0, 99);
        page = $urandom_range(0, 3);
        it.kind = (pick < 58) ? KIND_LOOKUP : (pick < 72) ? KIND_FIXED :
                  (pick < 86) ? KIND_BASE : KIND_MASK;
        it.word = {$urandom(), $urandom()};
        it.address = ADDR_W'({$urandom(), $urandom()});
        if (it.kind == KIND_FIXED)
            it.slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(FIXED_WORDS, 15))
                                                  : SLOT_W'($urandom_range(0, FIXED_WORDS - 1));
        else if (it.kind == KIND_LOOKUP)
            it.slot = SLOT_W'($urandom_range(0, 15));
        else
            it.slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(VAR_ENTRIES, 15))
                                                  : SLOT_W'($urandom_range(0, VAR_ENTRIES - 1));
        case (it.kind)
            KIND_BASE:
                if ($urandom_range(0, 4) != 0)
                    it.word[ADDR_W-1:12] = region_pages[page][ADDR_W-1:12];
            KIND_MASK:
                if ($urandom_range(0, 4) != 0)
                begin
                    // Contiguous mask from a random bit upwards, valid most of the time.
                    shift = $urandom_range(12, 44);
                    it.word = (64'hFFFF_FFFF_FFFF_FFFF << shift) | (it.word & 64'h7FF);
                    it.word[MASK_VALID_BIT] = ($urandom_range(0, 4) != 0);
                end
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    it.address = ADDR_W'($urandom_range(0, 32'h000F_FFFF));
                else if (pick < 8)
                begin
                    shift = $urandom_range(0, 30);
                    it.address = region_pages[page] ^
                                 (ADDR_W'($urandom()) & ((ADDR_W'(1) << shift) - ADDR_W'(1)));
                end
            end
        endcase
        return it;
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(cfg_reg_t which, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (which)
            REG_FIXED_ENABLE:   cfg_fixed_enable = value[0];
            REG_VARIABLE_COUNT: cfg_variable_count = value[3:0];
            default:            cfg_default_type = value[TYPE_W-1:0];
        endcase
    endtask

    // Wait until every word has been taken and every lookup answered, then let writes settle.
    task automatic wait_for_idle();
        do @(negedge clk);
        while (queued_words.size() != 0 || item_valid || predicted_types.size() != 0);
        repeat (ROW_SETTLE) @(posedge clk);
    endtask

    // Sender: bursts of random length with random gaps; a stalled word is held.
    always @(posedge clk)
    begin : word_driver
        item_word_t nxt;
        logic taken;
        taken = item_valid && !item_stall;
        if (taken)
        begin
            accepted_items <= accepted_items + 1;
            case (offered.kind)
                KIND_LOOKUP:
                    predicted_types.push_back(predict_mem_type(offered.address));
                KIND_FIXED:
                    if (offered.slot < FIXED_WORDS)
                        fixed_range_words[offered.slot] = offered.word;
                KIND_BASE:
                    if (offered.slot < VAR_ENTRIES)
                        var_base_words[offered.slot] = offered.word;
                default:
                    if (offered.slot < VAR_ENTRIES)
                        var_mask_words[offered.slot] = offered.word;
            endcase
        end
        if (rst_n && (!item_valid || taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (queued_words.size() > 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                nxt = queued_words.pop_front();
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                offered <= nxt;
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: stall patterns of its own, plus a long hold-off now and then.
    always @(posedge clk)
    begin : result_receiver
        logic stall_next;
        if (!rst_n)
            stall_next = 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (accepted_items >= next_hold_at)
        begin
            next_hold_at += HOLD_INTERVAL;
            hold_left = HOLD_LENGTH - 1;
            stall_next = 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_mode = stall_mode_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (pattern_mode)
                STALL_NONE:  stall_next = 1'b0;
                STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 6);
                default:     stall_next = ((pattern_left % 5) < 2);
            endcase
        end
        result_stall <= stall_next;
    end

    // Each accepted result word is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        logic [TYPE_W-1:0] wanted;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_types.size() == 0)
            begin
                $error("mem_type: result word with no lookup waiting, actual %02h", mem_type);
                fault_count++;
            end
            else
            begin
                wanted = predicted_types.pop_front();
                if (mem_type !== wanted)
                begin
                    $error("mem_type: expected %02h, actual %02h", wanted, mem_type);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mtrr_memory_type_resolver_test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int enable_plan [PLAN_STEPS];
        int count_plan [PLAN_STEPS];
        int default_plan [PLAN_STEPS];
        enable_plan = '{1, 0, 1, 1, 0, 1};
        count_plan = '{8, 3, 15, 0, 1, 8};
        default_plan = '{8'hA5, 8'hFF, 8'h00, 8'h5A, $urandom_range(0, 255), 8'h06};
        for (int i = 0; i < FIXED_WORDS; i++)
            fixed_range_words[i] = '0;
        for (int i = 0; i < VAR_ENTRIES; i++)
        begin
            var_base_words[i] = '0;
            var_mask_words[i] = '0;
        end
        region_pages[0] = ONE_MIB;
        for (int i = 1; i < 4; i++)
            region_pages[i] = (ADDR_W'({$urandom(), $urandom()}) | ONE_MIB) & PFN_MASK;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Straight after reset every lookup returns the zero default type.
        @(negedge clk);
        queue_item(KIND_LOOKUP, '0, '0, '0);
        queue_item(KIND_LOOKUP, '1, '1, '1);
        wait_for_idle();

        for (int p = 0; p < PLAN_STEPS; p++)
        begin
            write_register(REG_FIXED_ENABLE, 32'(enable_plan[p]));
            write_register(REG_VARIABLE_COUNT, 32'(count_plan[p]));
            write_register(REG_DEFAULT_TYPE, 32'(default_plan[p]));
            @(negedge clk);
            if (p == 0)
            begin
                // Known table contents, ignored out-of-range slots, and granule edges.
                queue_item(KIND_FIXED, 4'd0, 64'h0706_0504_0302_0100, '0);
                queue_item(KIND_FIXED, 4'd1, 64'h1716_1514_1312_1110, '0);
                queue_item(KIND_FIXED, 4'd2, 64'h1F1E_1D1C_1B1A_1918, '0);
                queue_item(KIND_FIXED, 4'd3, 64'h2726_2524_2322_2120, '0);
                queue_item(KIND_FIXED, 4'd10, 64'hFFFF_FFFF_FFFF_FFFF, '0);
                queue_item(KIND_FIXED, 4'd11, 64'hDEAD_BEEF_CAFE_F00D, '0);
                queue_item(KIND_FIXED, 4'd15, 64'h5555_AAAA_5555_AAAA, '0);
                queue_item(KIND_BASE, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
                queue_item(KIND_MASK, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
                queue_item(KIND_BASE, 4'd7, 64'h0000_0000_0000_0042, '0);
                queue_item(KIND_MASK, 4'd7, 64'h0000_0000_0000_0800, '0);
                queue_item(KIND_BASE, 4'd8, 64'h0000_0000_0000_0077, '1);
                queue_item(KIND_MASK, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, '1);
                queue_item(KIND_LOOKUP, '1, '1, ADDR_W'(32'h0000_0000));
                queue_item(KIND_LOOKUP, '1, '1, ADDR_W'(32'h0007_FFFF));
                queue_item(KIND_LOOKUP, '0, '0, ADDR_W'(32'h0008_0000));
                queue_item(KIND_LOOKUP, '0, '0, ADDR_W'(32'h000B_FFFF));
                queue_item(KIND_LOOKUP, '0, '0, ADDR_W'(32'h000C_0000));
                queue_item(KIND_LOOKUP, '0, '0, ADDR_W'(32'h000F_FFFF));
                queue_item(KIND_LOOKUP, '0, '0, ONE_MIB);
                queue_item(KIND_LOOKUP, '0, '0, '1);
            end
            for (int n = 0; n < RANDOM_WORDS; n++)
                queued_words.push_back(make_random_item());
            // The stimulus waits here until every lookup has been answered.
            wait_for_idle();
        end

        if (fault_count == 0)
            $display("mtrr_memory_type_resolver_test passed");
        else
            $display("mtrr_memory_type_resolver_test failed");
        $finish;
    end

endmodule

/* mtrr_memory_type_resolver.f */
design/mtrr_pkg.sv
design/mtrr_fixed.sv
design/mtrr_cell.sv
design/mtrr_memory_type_resolver.sv
tb/mtrr_memory_type_resolver_test.sv
